FILE: rtl/csc_pkg.sv
// Shared types and constants for the speed-and-cadence measurement block.
// Used by the frame parser, the speed unit, the top level and the checker.
`default_nettype none

package csc_pkg;

    // Input command codes
    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_SPEED = 1'b1;

    // Result kind codes
    localparam logic RESULT_STATUS = 1'b0;
    localparam logic RESULT_SPEED  = 1'b1;

    localparam logic [15:0] CIRC_RESET = 16'd67;

    // Frame layout: flags byte, then wheel record, then crank record
    localparam int          SHADOW_BYTES = 10;
    localparam logic [3:0]  POS_MAX      = 4'd15;
    localparam logic [3:0]  WHEEL_BYTES  = 4'd6;
    localparam logic [3:0]  CRANK_BYTES  = 4'd4;

    // Speed scale: 1024 ticks/s * 0.00223694 mph per mm/s, in fixed point
    localparam longint unsigned SCALE_NUM = 64'd22906;
    localparam longint unsigned SCALE_DEN = 64'd10000;

    localparam int SPEED_W   = 24;
    localparam int REVS_W    = 32;
    localparam int TIME_W    = 16;
    localparam int CIRC_W    = 16;
    localparam int STEP_CNT_W = 5;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_SPEED,
        TOP_PEND
    } top_state_t;

    typedef enum logic [1:0] {
        SPD_IDLE,
        SPD_MUL,
        SPD_CHK,
        SPD_DIV
    } spd_state_t;

    // Committed record values and frame status from the parser
    typedef struct packed {
        logic [7:0]  flags_valid;
        logic        frame_error;
        logic [31:0] wheel_revs;
        logic [15:0] wheel_time;
        logic [15:0] crank_revs;
        logic [15:0] crank_time;
    } rec_t;

endpackage

`default_nettype wire

FILE: rtl/csc_frame_parse.sv
// Frame byte assembly and record commit on the last byte of a frame.
// Depends on csc_pkg for the record struct and frame layout constants.
`default_nettype none

module csc_frame_parse (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_we,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output csc_pkg::rec_t    rec
);

    logic [3:0]    pos_reg;
    logic [3:0]    pos_next;
    logic [7:0]    flags_reg;
    logic [7:0]    flags_next;
    logic [7:0]    shadow_reg  [csc_pkg::SHADOW_BYTES];
    logic [7:0]    shadow_next [csc_pkg::SHADOW_BYTES];
    csc_pkg::rec_t rec_reg;
    csc_pkg::rec_t rec_next;

    logic [3:0]  len;
    logic        has_wheel;
    logic        has_crank;
    logic        err_wheel;
    logic        err_crank;
    logic        frame_err;

    always_comb
    begin
        for (int i = 0; i < csc_pkg::SHADOW_BYTES; i++)
        begin
            shadow_next[i] = (byte_we && pos_reg == 4'(i + 1)) ? data_byte : shadow_reg[i];
        end

        flags_next = (byte_we && pos_reg == 4'd0) ? data_byte : flags_reg;
        len        = (pos_reg == csc_pkg::POS_MAX) ? pos_reg : pos_reg + 4'd1;

        has_wheel = flags_next[0];
        has_crank = flags_next[1];
        err_wheel = has_wheel && (len < 4'd1 + csc_pkg::WHEEL_BYTES);
        // crank record sits after the wheel record when both are flagged
        err_crank = has_crank && !err_wheel &&
                    (len < (has_wheel ? 4'd1 + csc_pkg::WHEEL_BYTES + csc_pkg::CRANK_BYTES
                                      : 4'd1 + csc_pkg::CRANK_BYTES));
        frame_err = err_wheel || err_crank;

        pos_next = pos_reg;
        rec_next = rec_reg;
        if (byte_we)
        begin
            pos_next = len;
            if (last_byte)
            begin
                pos_next = 4'd0;
                rec_next.frame_error = frame_err;
                rec_next.flags_valid = frame_err ? 8'd0 : flags_next;
                if (has_wheel && !err_wheel)
                begin
                    rec_next.wheel_revs = {shadow_next[3], shadow_next[2],
                                           shadow_next[1], shadow_next[0]};
                    rec_next.wheel_time = {shadow_next[5], shadow_next[4]};
                end
                if (has_crank && !frame_err)
                begin
                    if (has_wheel)
                    begin
                        rec_next.crank_revs = {shadow_next[7], shadow_next[6]};
                        rec_next.crank_time = {shadow_next[9], shadow_next[8]};
                    end
                    else
                    begin
                        rec_next.crank_revs = {shadow_next[1], shadow_next[0]};
                        rec_next.crank_time = {shadow_next[3], shadow_next[2]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            flags_reg <= 8'd0;
            rec_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            rec_reg   <= rec_next;
        end
    end

    // shadow bytes are only read after being written in the same frame
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < csc_pkg::SHADOW_BYTES; i++)
        begin
            shadow_reg[i] <= shadow_next[i];
        end
    end

    assign rec = rec_reg;

endmodule

`default_nettype wire

FILE: rtl/csc_speed_unit.sv
// Wheel speed unit: bit-serial shift-add multiply, then restoring divide.
// Depends on csc_pkg for state type and field widths.
`default_nettype none

module csc_speed_unit #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [csc_pkg::REVS_W-1:0]    wheel_revs,
    input  wire logic [csc_pkg::TIME_W-1:0]    wheel_time,
    input  wire logic [csc_pkg::CIRC_W-1:0]    circumference,
    output logic                               done,
    output logic [csc_pkg::SPEED_W-1:0]        speed,
    output logic                               computed
);

    localparam longint unsigned SCALE =
        (csc_pkg::SCALE_NUM * (64'd1 << SPEED_FRAC_BITS)) / csc_pkg::SCALE_DEN;
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int M_W     = csc_pkg::CIRC_W + SCALE_W;
    localparam int N_W     = csc_pkg::REVS_W + M_W;
    localparam int SW      = csc_pkg::SPEED_W;
    localparam int TW      = csc_pkg::TIME_W;
    localparam int RW      = csc_pkg::REVS_W;
    localparam int CW      = csc_pkg::STEP_CNT_W;

    csc_pkg::spd_state_t state_reg;
    csc_pkg::spd_state_t state_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [RW-1:0]       prior_revs_reg;
    logic [RW-1:0]       prior_revs_next;
    logic [TW-1:0]       prior_time_reg;
    logic [TW-1:0]       prior_time_next;
    logic [TW-1:0]       dt_reg;
    logic [TW-1:0]       dt_next;
    logic [M_W-1:0]      m_reg;
    logic [M_W-1:0]      m_next;
    logic [N_W-1:0]      p_reg;
    logic [N_W-1:0]      p_next;
    logic [TW-1:0]       rem_reg;
    logic [TW-1:0]       rem_next;
    logic [SW-1:0]       speed_reg;
    logic [SW-1:0]       speed_next;
    logic                computed_reg;
    logic                computed_next;

    logic [M_W:0]        add_sum;
    logic                hi_ge;
    logic [TW:0]         rem_try;
    logic [TW:0]         rem_sub;
    logic                fits;
    logic [SW-1:0]       quot_shift;

    always_comb
    begin
        add_sum    = {1'b0, p_reg[N_W-1:RW]} + {1'b0, m_reg};
        hi_ge      = p_reg[N_W-1:SW] >= (N_W - SW)'(dt_reg);
        rem_try    = {rem_reg, p_reg[SW-1]};
        fits       = rem_try >= {1'b0, dt_reg};
        rem_sub    = rem_try - {1'b0, dt_reg};
        quot_shift = {p_reg[SW-2:0], fits};

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        prior_revs_next = prior_revs_reg;
        prior_time_next = prior_time_reg;
        dt_next         = dt_reg;
        m_next          = m_reg;
        p_next          = p_reg;
        rem_next        = rem_reg;
        speed_next      = speed_reg;
        computed_next   = computed_reg;
        done            = 1'b0;

        unique case (state_reg)
            csc_pkg::SPD_IDLE:
            begin
                if (start)
                begin
                    prior_revs_next = wheel_revs;
                    prior_time_next = wheel_time;
                    dt_next         = wheel_time - prior_time_reg;
                    m_next          = M_W'(circumference) * M_W'(SCALE);
                    p_next          = {{M_W{1'b0}}, wheel_revs - prior_revs_reg};
                    cnt_next        = '0;
                    state_next      = csc_pkg::SPD_MUL;
                end
            end
            csc_pkg::SPD_MUL:
            begin
                // shift-add, one multiplier bit per cycle, LSB first
                if (p_reg[0])
                    p_next = {add_sum, p_reg[RW-1:1]};
                else
                    p_next = {1'b0, p_reg[N_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(RW - 1))
                    state_next = csc_pkg::SPD_CHK;
            end
            csc_pkg::SPD_CHK:
            begin
                if (dt_reg == '0)
                begin
                    speed_next    = '0;
                    computed_next = 1'b0;
                    done          = 1'b1;
                    state_next    = csc_pkg::SPD_IDLE;
                end
                else if (hi_ge)
                begin
                    // quotient would not fit the result: saturate
                    speed_next    = '1;
                    computed_next = 1'b1;
                    done          = 1'b1;
                    state_next    = csc_pkg::SPD_IDLE;
                end
                else
                begin
                    rem_next   = p_reg[SW+TW-1:SW];
                    cnt_next   = '0;
                    state_next = csc_pkg::SPD_DIV;
                end
            end
            csc_pkg::SPD_DIV:
            begin
                rem_next           = fits ? rem_sub[TW-1:0] : rem_try[TW-1:0];
                p_next[SW-1:0]     = quot_shift;
                cnt_next           = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SW - 1))
                begin
                    speed_next    = quot_shift;
                    computed_next = 1'b1;
                    done          = 1'b1;
                    state_next    = csc_pkg::SPD_IDLE;
                end
            end
            default:
            begin
                state_next = csc_pkg::SPD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= csc_pkg::SPD_IDLE;
            cnt_reg        <= '0;
            prior_revs_reg <= '0;
            prior_time_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            prior_revs_reg <= prior_revs_next;
            prior_time_reg <= prior_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        m_reg        <= m_next;
        p_reg        <= p_next;
        rem_reg      <= rem_next;
        speed_reg    <= speed_next;
        computed_reg <= computed_next;
    end

    assign speed    = speed_reg;
    assign computed = computed_reg;

endmodule

`default_nettype wire

FILE: rtl/csc_measurement_parse_and_speed.sv
// Frame byte: a new word may follow in the next cycle. Last byte of a frame: record registered,
// status word loaded into the output register from the pending state once that register is free;
// input stalled until the load. Speed compute: 32-step shift-add multiply, one check step and a
// 24-step restoring divide in the speed unit; the divide is skipped if dt is zero or saturated.
// Reset (async, active low) clears records, prior values, handshake state; circumference = 67.
// Top level: handshake, configuration register and output register. Depends on csc_pkg.
`default_nettype none

module csc_measurement_parse_and_speed #(
    parameter int SPEED_FRAC_BITS = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data,

    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic         cmd,
    input  wire logic [7:0]   data_byte,
    input  wire logic         last_byte,

    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              result_kind,
    output logic              frame_error,
    output logic [7:0]        valid_flags,
    output logic [31:0]       wheel_revolutions,
    output logic [15:0]       wheel_event_time,
    output logic [15:0]       crank_revolutions,
    output logic [15:0]       crank_event_time,
    output logic [23:0]       speed_q8,
    output logic              speed_computed
);

    csc_pkg::top_state_t state_reg;
    csc_pkg::top_state_t state_next;
    logic                pend_kind_reg;
    logic                pend_kind_next;
    logic [15:0]         circ_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                result_kind_reg;
    logic                frame_error_reg;
    logic [7:0]          valid_flags_reg;
    logic [31:0]         wheel_revs_reg;
    logic [15:0]         wheel_time_reg;
    logic [15:0]         crank_revs_reg;
    logic [15:0]         crank_time_reg;
    logic [23:0]         speed_reg;
    logic                computed_reg;

    logic                accept;
    logic                byte_we;
    logic                spd_start;
    logic                spd_done;
    logic [23:0]         spd_speed;
    logic                spd_computed;
    logic                load;
    csc_pkg::rec_t       rec;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != csc_pkg::TOP_IDLE);
    assign accept    = in_valid && !in_stall;
    assign byte_we   = accept && (cmd == csc_pkg::CMD_BYTE);
    assign spd_start = accept && (cmd == csc_pkg::CMD_SPEED);

    csc_frame_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_we   (byte_we),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .rec       (rec)
    );

    csc_speed_unit #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_speed (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (spd_start),
        .wheel_revs    (rec.wheel_revs),
        .wheel_time    (rec.wheel_time),
        .circumference (circ_reg),
        .done          (spd_done),
        .speed         (spd_speed),
        .computed      (spd_computed)
    );

    always_comb
    begin
        state_next     = state_reg;
        pend_kind_next = pend_kind_reg;
        load           = 1'b0;

        unique case (state_reg)
            csc_pkg::TOP_IDLE:
            begin
                if (spd_start)
                begin
                    state_next = csc_pkg::TOP_SPEED;
                end
                else if (byte_we && last_byte)
                begin
                    pend_kind_next = csc_pkg::RESULT_STATUS;
                    state_next     = csc_pkg::TOP_PEND;
                end
            end
            csc_pkg::TOP_SPEED:
            begin
                if (spd_done)
                begin
                    pend_kind_next = csc_pkg::RESULT_SPEED;
                    state_next     = csc_pkg::TOP_PEND;
                end
            end
            csc_pkg::TOP_PEND:
            begin
                // hold until the output register is free or draining
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = csc_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = csc_pkg::TOP_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csc_pkg::TOP_IDLE;
            pend_kind_reg <= csc_pkg::RESULT_STATUS;
            out_valid_reg <= 1'b0;
            circ_reg      <= csc_pkg::CIRC_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pend_kind_reg <= pend_kind_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                circ_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_kind_reg <= pend_kind_reg;
            frame_error_reg <= (pend_kind_reg == csc_pkg::RESULT_STATUS) && rec.frame_error;
            valid_flags_reg <= rec.flags_valid;
            wheel_revs_reg  <= rec.wheel_revs;
            wheel_time_reg  <= rec.wheel_time;
            crank_revs_reg  <= rec.crank_revs;
            crank_time_reg  <= rec.crank_time;
            if (pend_kind_reg == csc_pkg::RESULT_SPEED)
            begin
                speed_reg    <= spd_speed;
                computed_reg <= spd_computed;
            end
            else
            begin
                speed_reg    <= '0;
                computed_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = result_kind_reg;
    assign frame_error       = frame_error_reg;
    assign valid_flags       = valid_flags_reg;
    assign wheel_revolutions = wheel_revs_reg;
    assign wheel_event_time  = wheel_time_reg;
    assign crank_revolutions = crank_revs_reg;
    assign crank_event_time  = crank_time_reg;
    assign speed_q8          = speed_reg;
    assign speed_computed    = computed_reg;

endmodule

`default_nettype wire

FILE: rtl/csc_checker.sv
// Port-level checks for the measurement block, bound to the top level.
// Depends on csc_pkg for command and result codes.
`default_nettype none

module csc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_stall,
    input wire logic         cmd,
    input wire logic         out_valid,
    input wire logic         out_stall,
    input wire logic         result_kind,
    input wire logic         frame_error,
    input wire logic [7:0]   valid_flags,
    input wire logic [31:0]  wheel_revolutions,
    input wire logic [23:0]  speed_q8,
    input wire logic         speed_computed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_kind) && $stable(speed_q8) &&
                                   $stable(wheel_revolutions))
        else $error("stalled output word changed");

    a_status_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == csc_pkg::RESULT_STATUS |->
            speed_q8 == 24'd0 && !speed_computed)
        else $error("status word carries a speed");

    a_error_clears_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_error |->
            valid_flags == 8'd0 && result_kind == csc_pkg::RESULT_STATUS)
        else $error("error word with flags or wrong kind");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == csc_pkg::CMD_SPEED |=> in_stall)
        else $error("new word taken while speed compute runs");

endmodule

bind csc_measurement_parse_and_speed csc_checker u_csc_checker (.*);

`default_nettype wire
